[rtl/jtl_pkg.sv]
package jtl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_LITERAL = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        KIND_LBRACE = 4'd0,
        KIND_RBRACE = 4'd1,
        KIND_LBRACK = 4'd2,
        KIND_RBRACK = 4'd3,
        KIND_COMMA  = 4'd4,
        KIND_COLON  = 4'd5,
        KIND_STRING = 4'd6,
        KIND_NUMBER = 4'd7,
        KIND_TRUE   = 4'd8,
        KIND_FALSE  = 4'd9,
        KIND_NULL   = 4'd10,
        KIND_ERROR  = 4'd11,
        KIND_END    = 4'd12
    } t_kind;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } t_lit;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int MaxTokens = 3;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] length;
    } t_token;

    typedef struct packed {
        t_token [MaxTokens-1:0] tok;
        logic   [1:0]           count;
    } t_bundle;

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        case (w)
            LIT_FALSE: lit_len = 3'd5;
            default:   lit_len = 3'd4;
        endcase
    endfunction

    function automatic t_kind lit_kind(input logic [1:0] w);
        case (w)
            LIT_FALSE: lit_kind = KIND_FALSE;
            LIT_NULL:  lit_kind = KIND_NULL;
            default:   lit_kind = KIND_TRUE;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            LIT_FALSE: begin
                case (i)
                    3'd0:    c = CH_F;
                    3'd1:    c = CH_A;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_S;
                    3'd4:    c = CH_E;
                    default: c = 8'h00;
                endcase
            end
            LIT_NULL: begin
                case (i)
                    3'd0:    c = CH_N;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_L;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    c = CH_T;
                    3'd1:    c = CH_R;
                    3'd2:    c = CH_U;
                    3'd3:    c = CH_E;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic num_char(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_DOT) || (b == CH_MINUS);
    endfunction

endpackage

[rtl/jtl_if.sv]
interface jtl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface jtl_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        run_last;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output run_last, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input run_last, output ready
    );
endinterface

[rtl/jtl_lexer_core.sv]
module jtl_lexer_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jtl_byte_if.sink         i_byte,
    input  logic             i_load_ok,
    output logic             o_load,
    output jtl_pkg::t_bundle o_bundle
);

    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_last;

    jtl_pkg::t_mode         r_mode, n_mode;
    logic [1:0]             r_wh, n_wh;
    logic [2:0]             r_ix, n_ix;
    logic [OFFSET_BITS-1:0] r_ps, n_ps;
    logic [OFFSET_BITS-1:0] r_pl, n_pl;
    logic [OFFSET_BITS-1:0] r_off, n_off;

    jtl_pkg::t_bundle       bundle;
    logic                   consume;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : OFFSET_BITS'(v + 1'b1);
    endfunction

    function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

    function automatic jtl_pkg::t_token mk(
        input jtl_pkg::t_kind k, input logic [31:0] s, input logic [31:0] l
    );
        jtl_pkg::t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        return t;
    endfunction

    always_comb begin
        logic       start_idle;
        logic [1:0] cnt;
        logic [1:0] w;
        start_idle = 1'b0;
        cnt        = 2'd0;
        w          = jtl_pkg::LIT_TRUE;
        bundle     = '0;
        n_mode     = r_mode;
        n_wh       = r_wh;
        n_ix       = r_ix;
        n_ps       = r_ps;
        n_pl       = r_pl;
        n_off      = sat_inc(r_off);

        case (r_mode)
            jtl_pkg::MODE_STRING: begin
                if (r_byte == jtl_pkg::CH_QUOTE) begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_STRING, to32(r_ps), to32(r_pl));
                    cnt = cnt + 2'd1;
                    n_mode = jtl_pkg::MODE_IDLE;
                end else begin
                    n_pl = sat_inc(r_pl);
                end
            end
            jtl_pkg::MODE_NUMBER: begin
                if (jtl_pkg::num_char(r_byte)) begin
                    n_pl = sat_inc(r_pl);
                end else begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_NUMBER, to32(r_ps), to32(r_pl));
                    cnt = cnt + 2'd1;
                    n_mode = jtl_pkg::MODE_IDLE;
                    start_idle = 1'b1;
                end
            end
            jtl_pkg::MODE_LITERAL: begin
                w = (r_wh == 2'd3) ? jtl_pkg::LIT_TRUE : r_wh;
                if ((r_ix < jtl_pkg::lit_len(w)) && (r_byte == jtl_pkg::lit_char(w, r_ix))) begin
                    n_ix = r_ix + 3'd1;
                    if (n_ix >= jtl_pkg::lit_len(w)) begin
                        bundle.tok[cnt] = mk(jtl_pkg::lit_kind(w), to32(r_ps),
                                             32'(jtl_pkg::lit_len(w)));
                        cnt = cnt + 2'd1;
                        n_mode = jtl_pkg::MODE_IDLE;
                    end
                end else begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_ERROR, to32(r_ps), 32'(r_ix) + 32'd1);
                    cnt = cnt + 2'd1;
                    n_mode = jtl_pkg::MODE_IDLE;
                end
            end
            default: begin
                start_idle = 1'b1;
            end
        endcase

        if (start_idle) begin
            case (r_byte)
                jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_CR, jtl_pkg::CH_LF: begin
                end
                jtl_pkg::CH_LBRACE: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_LBRACE, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_RBRACE: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_RBRACE, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_LBRACK: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_LBRACK, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_RBRACK: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_RBRACK, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_COMMA: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_COMMA, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_COLON: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_COLON, to32(r_off), 32'd1);
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::CH_QUOTE: begin
                    n_mode = jtl_pkg::MODE_STRING;
                    n_ps   = sat_inc(r_off);
                    n_pl   = '0;
                end
                jtl_pkg::CH_T: begin
                    n_mode = jtl_pkg::MODE_LITERAL;
                    n_wh   = jtl_pkg::LIT_TRUE;
                    n_ix   = 3'd1;
                    n_ps   = r_off;
                end
                jtl_pkg::CH_F: begin
                    n_mode = jtl_pkg::MODE_LITERAL;
                    n_wh   = jtl_pkg::LIT_FALSE;
                    n_ix   = 3'd1;
                    n_ps   = r_off;
                end
                jtl_pkg::CH_N: begin
                    n_mode = jtl_pkg::MODE_LITERAL;
                    n_wh   = jtl_pkg::LIT_NULL;
                    n_ix   = 3'd1;
                    n_ps   = r_off;
                end
                default: begin
                    if (jtl_pkg::num_char(r_byte)) begin
                        n_mode = jtl_pkg::MODE_NUMBER;
                        n_ps   = r_off;
                        n_pl   = OFFSET_BITS'(1);
                    end else begin
                        bundle.tok[cnt] = mk(jtl_pkg::KIND_ERROR, to32(r_off), 32'd1);
                        cnt = cnt + 2'd1;
                    end
                end
            endcase
        end

        if (r_last) begin
            case (n_mode)
                jtl_pkg::MODE_NUMBER: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_NUMBER, to32(n_ps), to32(n_pl));
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::MODE_STRING: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_ERROR, to32(n_ps), to32(n_pl));
                    cnt = cnt + 2'd1;
                end
                jtl_pkg::MODE_LITERAL: begin
                    bundle.tok[cnt] = mk(jtl_pkg::KIND_ERROR, to32(n_ps), 32'(n_ix));
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            bundle.tok[cnt] = mk(jtl_pkg::KIND_END, to32(n_off), 32'd0);
            cnt = cnt + 2'd1;
            n_mode = jtl_pkg::MODE_IDLE;
            n_wh   = 2'd0;
            n_ix   = 3'd0;
            n_ps   = '0;
            n_pl   = '0;
            n_off  = '0;
        end

        bundle.count = cnt;
    end

    assign consume      = r_in_valid && ((bundle.count == 2'd0) || i_load_ok);
    assign o_load       = consume && (bundle.count != 2'd0);
    assign o_bundle     = bundle;
    assign i_byte.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.source_byte;
            r_last <= i_byte.end_of_source;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jtl_pkg::MODE_IDLE;
            r_wh   <= 2'd0;
            r_ix   <= 3'd0;
            r_ps   <= '0;
            r_pl   <= '0;
            r_off  <= '0;
        end else if (consume) begin
            r_mode <= n_mode;
            r_wh   <= n_wh;
            r_ix   <= n_ix;
            r_ps   <= n_ps;
            r_pl   <= n_pl;
            r_off  <= n_off;
        end
    end

endmodule

[rtl/jtl_token_serializer.sv]
module jtl_token_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jtl_pkg::t_bundle i_bundle,
    output logic             o_load_ok,
    jtl_token_if.source      o_token
);

    logic             r_valid;
    logic [1:0]       r_idx;
    jtl_pkg::t_bundle r_bundle;
    logic             is_last;
    jtl_pkg::t_token  head;

    assign is_last   = (r_idx == (r_bundle.count - 2'd1));
    assign o_load_ok = !r_valid || (o_token.ready && is_last);
    assign head      = r_bundle.tok[r_idx];

    assign o_token.valid        = r_valid;
    assign o_token.token_kind   = head.kind;
    assign o_token.token_start  = head.start;
    assign o_token.token_length = head.length;
    assign o_token.run_last     = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && o_token.ready) begin
            if (is_last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

[rtl/json_token_lexer_top.sv]
// JSON token lexer: takes source text one byte per beat and returns tokens (kind, start
// offset, length), skipping whitespace; strings carry no escape handling, bad literals and
// unknown bytes give error tokens, and an end token follows the byte flagged end_of_source.
// A byte passes from the input register through the lexer logic into the token register,
// so bytes stream at one per cycle while each yields at most one token and the output is
// not stalled; a byte that yields k tokens (up to 3) holds the token register for k output
// beats, which sets the rate on token-dense text. Bytes that yield no token move on even
// while the output stalls. There is no clearing pass.
module json_token_lexer_top #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jtl_byte_if.sink    i_byte,
    jtl_token_if.source o_token
);

    logic             load;
    logic             load_ok;
    jtl_pkg::t_bundle bundle;

    jtl_lexer_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_load_ok (load_ok),
        .o_load    (load),
        .o_bundle  (bundle)
    );

    jtl_token_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_bundle  (bundle),
        .o_load_ok (load_ok),
        .o_token   (o_token)
    );

endmodule

[rtl/jtl_checker.sv]
module jtl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_token_kind,
    input logic [31:0] i_token_start,
    input logic [31:0] i_token_length,
    input logic        i_run_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_token_kind) && $stable(i_token_start)
             && $stable(i_token_length) && $stable(i_run_last)))
        else $error("token beat changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_token_kind <= jtl_pkg::KIND_END))
        else $error("token kind out of range");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_token_kind == jtl_pkg::KIND_END)) |->
            (i_run_last && (i_token_length == 32'd0)))
        else $error("end token not last or has length");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_token_kind <= jtl_pkg::KIND_COLON)) |-> (i_token_length == 32'd1))
        else $error("punctuation token length not one");

endmodule

bind json_token_lexer_top jtl_checker u_jtl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_token.valid),
    .i_out_ready    (o_token.ready),
    .i_token_kind   (o_token.token_kind),
    .i_token_start  (o_token.token_start),
    .i_token_length (o_token.token_length),
    .i_run_last     (o_token.run_last)
);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytes = 220;
    localparam int HoldCycles  = 240;
    localparam int SettleCycles = 8;

    typedef struct {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_src_item;

    typedef struct packed {
        jtl_pkg::t_kind kind;
        logic [31:0]    start;
        logic [31:0]    length;
        logic           last;
    } t_tok;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jtl_byte_if  byte_bus ();
    jtl_token_if token_bus ();

    json_token_lexer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_token (token_bus)
    );

    always #6 i_clk = ~i_clk;

    t_src_item pending_bytes [$];
    t_tok      expected_tokens [$];
    t_tok      step_tokens [$];

    string lit_words [3] = '{"true", "false", "null"};

    jtl_pkg::t_mode lex_state;
    jtl_pkg::t_lit  lit_sel;
    logic [2:0]     lit_pos;
    logic [31:0]    tok_start;
    logic [31:0]    tok_len;
    logic [31:0]    next_offset;

    int offer_count = 0;
    int accept_count = 0;
    int source_count = 0;
    int token_count = 0;
    int error_token_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic hold_off = 1'b0;

    function automatic logic [31:0] sat_next(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic numeric_char(input logic [7:0] b);
        return (b >= jtl_pkg::CH_ZERO && b <= jtl_pkg::CH_NINE)
            || b == jtl_pkg::CH_DOT || b == jtl_pkg::CH_MINUS;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count[8:7] == 2'b00) return 0;
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic reset_lexer_state();
        lex_state   = jtl_pkg::MODE_IDLE;
        lit_sel     = jtl_pkg::LIT_TRUE;
        lit_pos     = 3'd0;
        tok_start   = 32'd0;
        tok_len     = 32'd0;
        next_offset = 32'd0;
    endtask

    task automatic add_token(input jtl_pkg::t_kind k, input logic [31:0] s,
                             input logic [31:0] l);
        t_tok t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic open_token(input logic [7:0] b, input logic [31:0] o);
        case (b)
            jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_CR, jtl_pkg::CH_LF: ;
            jtl_pkg::CH_LBRACE: add_token(jtl_pkg::KIND_LBRACE, o, 32'd1);
            jtl_pkg::CH_RBRACE: add_token(jtl_pkg::KIND_RBRACE, o, 32'd1);
            jtl_pkg::CH_LBRACK: add_token(jtl_pkg::KIND_LBRACK, o, 32'd1);
            jtl_pkg::CH_RBRACK: add_token(jtl_pkg::KIND_RBRACK, o, 32'd1);
            jtl_pkg::CH_COMMA:  add_token(jtl_pkg::KIND_COMMA, o, 32'd1);
            jtl_pkg::CH_COLON:  add_token(jtl_pkg::KIND_COLON, o, 32'd1);
            jtl_pkg::CH_QUOTE: begin
                lex_state = jtl_pkg::MODE_STRING;
                tok_start = sat_next(o);
                tok_len   = 32'd0;
            end
            jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N: begin
                lex_state = jtl_pkg::MODE_LITERAL;
                if (b == jtl_pkg::CH_T) lit_sel = jtl_pkg::LIT_TRUE;
                else if (b == jtl_pkg::CH_F) lit_sel = jtl_pkg::LIT_FALSE;
                else lit_sel = jtl_pkg::LIT_NULL;
                lit_pos   = 3'd1;
                tok_start = o;
            end
            default: begin
                if (numeric_char(b)) begin
                    lex_state = jtl_pkg::MODE_NUMBER;
                    tok_start = o;
                    tok_len   = 32'd1;
                end else begin
                    add_token(jtl_pkg::KIND_ERROR, o, 32'd1);
                end
            end
        endcase
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic eos);
        logic [31:0] o;
        int          w_len;
        logic [7:0]  want;
        o = next_offset;
        step_tokens.delete();
        case (lex_state)
            jtl_pkg::MODE_STRING: begin
                if (b == jtl_pkg::CH_QUOTE) begin
                    add_token(jtl_pkg::KIND_STRING, tok_start, tok_len);
                    lex_state = jtl_pkg::MODE_IDLE;
                end else begin
                    tok_len = sat_next(tok_len);
                end
            end
            jtl_pkg::MODE_NUMBER: begin
                if (numeric_char(b)) begin
                    tok_len = sat_next(tok_len);
                end else begin
                    add_token(jtl_pkg::KIND_NUMBER, tok_start, tok_len);
                    lex_state = jtl_pkg::MODE_IDLE;
                    open_token(b, o);
                end
            end
            jtl_pkg::MODE_LITERAL: begin
                w_len = lit_words[lit_sel].len();
                want  = lit_words[lit_sel][lit_pos];
                if (int'(lit_pos) < w_len && b == want) begin
                    lit_pos = lit_pos + 3'd1;
                    if (int'(lit_pos) >= w_len) begin
                        add_token(jtl_pkg::t_kind'(jtl_pkg::KIND_TRUE + lit_sel), tok_start,
                                  32'(w_len));
                        lex_state = jtl_pkg::MODE_IDLE;
                    end
                end else begin
                    add_token(jtl_pkg::KIND_ERROR, tok_start, 32'(lit_pos) + 32'd1);
                    lex_state = jtl_pkg::MODE_IDLE;
                end
            end
            default: open_token(b, o);
        endcase
        next_offset = sat_next(o);
        if (eos) begin
            case (lex_state)
                jtl_pkg::MODE_NUMBER:  add_token(jtl_pkg::KIND_NUMBER, tok_start, tok_len);
                jtl_pkg::MODE_STRING:  add_token(jtl_pkg::KIND_ERROR, tok_start, tok_len);
                jtl_pkg::MODE_LITERAL: add_token(jtl_pkg::KIND_ERROR, tok_start, 32'(lit_pos));
                default: ;
            endcase
            add_token(jtl_pkg::KIND_END, next_offset, 32'd0);
            reset_lexer_state();
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_token();
        t_tok want;
        token_count++;
        if (token_bus.token_kind == jtl_pkg::KIND_ERROR) error_token_count++;
        if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                token_bus.token_kind, token_bus.token_start, token_bus.token_length));
        end else begin
            want = expected_tokens.pop_front();
            if (token_bus.token_kind != want.kind)
                note_mismatch($sformatf("token %0d kind %0d, want %s",
                    token_count, token_bus.token_kind, want.kind.name()));
            if (token_bus.token_start != want.start)
                note_mismatch($sformatf("token %0d start %0d, want %0d",
                    token_count, token_bus.token_start, want.start));
            if (token_bus.token_length != want.length)
                note_mismatch($sformatf("token %0d length %0d, want %0d",
                    token_count, token_bus.token_length, want.length));
            if (token_bus.run_last != want.last)
                note_mismatch($sformatf("token %0d run_last %0b, want %0b",
                    token_count, token_bus.run_last, want.last));
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_src_item item;
        item.text_byte = b;
        item.last_byte = 1'b0;
        pending_bytes.push_back(item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic mark_end();
        pending_bytes[pending_bytes.size() - 1].last_byte = 1'b1;
    endtask

    function automatic logic [7:0] random_numeric();
        int r;
        r = $urandom_range(0, 11);
        if (r < 10) return jtl_pkg::CH_ZERO + 8'(r);
        return (r == 10) ? jtl_pkg::CH_DOT : jtl_pkg::CH_MINUS;
    endfunction

    task automatic add_random_source();
        int         n_tok;
        int         pick;
        int         len;
        int         w;
        logic [7:0] b;
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                case ($urandom_range(0, 5))
                    0: push_byte(jtl_pkg::CH_LBRACE);
                    1: push_byte(jtl_pkg::CH_RBRACE);
                    2: push_byte(jtl_pkg::CH_LBRACK);
                    3: push_byte(jtl_pkg::CH_RBRACK);
                    4: push_byte(jtl_pkg::CH_COMMA);
                    default: push_byte(jtl_pkg::CH_COLON);
                endcase
            end else if (pick < 45) begin
                push_byte(jtl_pkg::CH_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    b = 8'($urandom_range(0, 255));
                    push_byte((b == jtl_pkg::CH_QUOTE) ? jtl_pkg::CH_SPACE : b);
                end
                if ($urandom_range(0, 9) != 0) push_byte(jtl_pkg::CH_QUOTE);
            end else if (pick < 60) begin
                len = $urandom_range(1, 5);
                repeat (len) push_byte(random_numeric());
            end else if (pick < 75) begin
                w   = $urandom_range(0, 2);
                len = lit_words[w].len();
                if ($urandom_range(0, 3) != 0) begin
                    push_text(lit_words[w]);
                end else begin
                    len = $urandom_range(1, len - 1);
                    for (int i = 0; i < len; i++) push_byte(lit_words[w][i]);
                    b = 8'($urandom_range(0, 255));
                    if (b == lit_words[w][len]) b = b ^ 8'h01;
                    push_byte(b);
                end
            end else if (pick < 88) begin
                len = $urandom_range(1, 3);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0: push_byte(jtl_pkg::CH_SPACE);
                        1: push_byte(jtl_pkg::CH_TAB);
                        2: push_byte(jtl_pkg::CH_CR);
                        default: push_byte(jtl_pkg::CH_LF);
                    endcase
                end
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
        mark_end();
    endtask

    always @(negedge i_clk) begin
        t_src_item item;
        if (!i_rst_n) begin
            byte_bus.valid <= 1'b0;
        end else if (!(byte_bus.valid && accept_count != offer_count)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                byte_bus.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                item = pending_bytes.pop_front();
                byte_bus.source_byte   <= item.text_byte;
                byte_bus.end_of_source <= item.last_byte;
                byte_bus.valid         <= 1'b1;
                offer_count = offer_count + 1;
                send_gap = pick_gap();
            end else begin
                byte_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            token_bus.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            token_bus.ready <= 1'b0;
        end else begin
            token_bus.ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (i_rst_n) begin
            if (token_bus.valid && token_bus.ready) check_token();
            if (byte_bus.valid && byte_bus.ready) begin
                lex_byte(byte_bus.source_byte, byte_bus.end_of_source);
                accept_count = accept_count + 1;
                if (byte_bus.end_of_source) source_count = source_count + 1;
            end
        end
    end

    initial begin
        while (accept_count < 60) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        reset_lexer_state();

        // punctuation, empty string, true, number closed by a brace on the last byte
        push_text("{\"\":[true],7}");
        mark_end();
        // false, bad literal, unknown bytes at both extremes, string left open
        push_text("falsenx");
        push_byte(8'h00);
        push_byte(8'hff);
        push_text("\"z");
        mark_end();
        // null, then a literal left open at the last byte
        push_text("null,tr");
        mark_end();
        while (pending_bytes.size() < RandomBytes) add_random_source();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || accept_count != offer_count) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        $display("lexed %0d bytes over %0d sources, checked %0d tokens (%0d error tokens)",
            accept_count, source_count, token_count, error_token_count);
        $display("output stalled for %0d cycles once with input still offered", HoldCycles);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jtl_pkg.sv
rtl/jtl_if.sv
rtl/jtl_lexer_core.sv
rtl/jtl_token_serializer.sv
rtl/json_token_lexer_top.sv
rtl/jtl_checker.sv
tb/tb.sv
